@@ rtl/dtcr_pkg.sv @@
// ----------------------------------------------------------------------------
// dtcr_pkg: shared definitions for the dual timer/counter register block
// Register addresses, operation codes, mode codes and bit positions for the
// TCON, TMOD and port-3 layouts, and the function that advances a timer.
// ----------------------------------------------------------------------------
package dtcr_pkg;

  // Operation codes carried by each item.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Special-function register addresses.
  localparam logic [7:0] ADDR_TCON = 8'h88;
  localparam logic [7:0] ADDR_TMOD = 8'h89;
  localparam logic [7:0] ADDR_TL0  = 8'h8A;
  localparam logic [7:0] ADDR_TL1  = 8'h8B;
  localparam logic [7:0] ADDR_TH0  = 8'h8C;
  localparam logic [7:0] ADDR_TH1  = 8'h8D;

  // Timer mode codes.
  localparam logic [1:0] MODE_16BIT  = 2'd1;
  localparam logic [1:0] MODE_RELOAD = 2'd2;

  // TCON bit positions.
  localparam int TF1_BIT = 7;
  localparam int TR1_BIT = 6;
  localparam int TF0_BIT = 5;
  localparam int TR0_BIT = 4;

  // TMOD bit positions.
  localparam int GATE1_BIT = 7;
  localparam int CT1_BIT   = 6;
  localparam int GATE0_BIT = 3;
  localparam int CT0_BIT   = 2;

  // Port-3 pin positions.
  localparam int INT0_PIN = 2;
  localparam int INT1_PIN = 3;
  localparam int T0_PIN   = 4;
  localparam int T1_PIN   = 5;

  // Result of advancing one timer by one count.
  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic       ovf;
  } cnt_t;

  // Advance a timer pair by one count in the given mode. Modes 0 and 3 hold.
  function automatic cnt_t advance(input logic [1:0] mode, input logic [7:0] lo,
                                   input logic [7:0] hi);
    cnt_t        r;
    logic [16:0] sum16;
    logic [8:0]  sum8;
    r     = '{lo: lo, hi: hi, ovf: 1'b0};
    sum16 = {1'b0, hi, lo} + 17'd1;
    sum8  = {1'b0, lo} + 9'd1;
    if (mode == MODE_16BIT) begin
      r.lo  = sum16[7:0];
      r.hi  = sum16[15:8];
      r.ovf = sum16[16];
    end else if (mode == MODE_RELOAD) begin
      r.lo  = sum8[8] ? hi : sum8[7:0];
      r.ovf = sum8[8];
    end
    return r;
  endfunction

endpackage

@@ rtl/dual_timer_counter_registers.sv @@
// An item goes to the input register, then to the result register once that is empty or being taken.
// Throughput: one item per cycle while the result is not stalled; the register update is one short stage of logic.
// Reset: rst clears all timer registers, the pin sample and both valid flags.
// A stalled result holds while the input register can still take one more item.
// ----------------------------------------------------------------------------
// dual_timer_counter_registers: two 8051-style timers behind their SFRs
// Each item is a tick with port-3 pins, a register read, a register write or a no-op.
// Every item returns the read byte (zero unless it is a read), an address hit flag and both TF flags.
// ----------------------------------------------------------------------------
module dual_timer_counter_registers
  import dtcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [1:0] op,
  input  logic [7:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic [7:0] port_pins,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] read_data,
  output logic       addr_hit,
  output logic       overflow0,
  output logic       overflow1
);

  // Input register.
  logic       s1_valid;
  op_t        s1_op;
  logic [7:0] s1_addr;
  logic [7:0] s1_data;
  logic [7:0] s1_pins;

  // Architectural state.
  logic [7:0] tcon, tmod, tl0, th0, tl1, th1, last_pins;
  logic [7:0] tcon_next, tmod_next, tl0_next, th0_next, tl1_next, th1_next;
  logic [7:0] last_pins_next;

  logic       advance_en;
  logic       run0, run1, ct0, ct1, gate0, gate1, sample, go0, go1;
  logic [7:0] now_pins;
  logic [7:0] rd_value;
  logic       hit;
  cnt_t       t0_cnt, t1_cnt;

  // The stage moves when the result register is empty or being taken.
  assign advance_en = !rsp_valid || !rsp_stall;
  assign cmd_stall  = s1_valid && !advance_en;

  // Tick decisions, taken from the state before this item.
  always_comb begin
    run0     = tcon[TR0_BIT];
    run1     = tcon[TR1_BIT];
    ct0      = tmod[CT0_BIT];
    ct1      = tmod[CT1_BIT];
    gate0    = tmod[GATE0_BIT];
    gate1    = tmod[GATE1_BIT];
    sample   = (run0 && (ct0 || gate0)) || (run1 && (ct1 || gate1));
    now_pins = sample ? s1_pins : last_pins;
    go0      = run0 && (!gate0 || now_pins[INT0_PIN]) &&
               (!ct0 || (last_pins[T0_PIN] && !now_pins[T0_PIN]));
    go1      = run1 && (!gate1 || now_pins[INT1_PIN]) &&
               (!ct1 || (last_pins[T1_PIN] && !now_pins[T1_PIN]));
    t0_cnt   = advance(tmod[1:0], tl0, th0);
    t1_cnt   = advance(tmod[5:4], tl1, th1);
  end

  // Register read decode and address hit.
  always_comb begin
    hit      = 1'b1;
    rd_value = 8'd0;
    case (s1_addr)
      ADDR_TCON: rd_value = tcon;
      ADDR_TMOD: rd_value = tmod;
      ADDR_TL0:  rd_value = tl0;
      ADDR_TH0:  rd_value = th0;
      ADDR_TL1:  rd_value = tl1;
      ADDR_TH1:  rd_value = th1;
      default:   hit = 1'b0;
    endcase
  end

  // Next state for the item in the input register.
  always_comb begin
    tcon_next      = tcon;
    tmod_next      = tmod;
    tl0_next       = tl0;
    th0_next       = th0;
    tl1_next       = tl1;
    th1_next       = th1;
    last_pins_next = last_pins;
    case (s1_op)
      OP_TICK: begin
        last_pins_next = now_pins;
        if (go0) begin
          tl0_next = t0_cnt.lo;
          th0_next = t0_cnt.hi;
          if (t0_cnt.ovf) tcon_next[TF0_BIT] = 1'b1;
        end
        if (go1) begin
          tl1_next = t1_cnt.lo;
          th1_next = t1_cnt.hi;
          if (t1_cnt.ovf) tcon_next[TF1_BIT] = 1'b1;
        end
      end
      OP_WRITE: begin
        case (s1_addr)
          ADDR_TCON: tcon_next = s1_data;
          ADDR_TMOD: tmod_next = s1_data;
          ADDR_TL0:  tl0_next  = s1_data;
          ADDR_TH0:  th0_next  = s1_data;
          ADDR_TL1:  tl1_next  = s1_data;
          ADDR_TH1:  th1_next  = s1_data;
          default:   ;
        endcase
      end
      default: ;
    endcase
  end

  // Input register, state update and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      tcon      <= 8'd0;
      tmod      <= 8'd0;
      tl0       <= 8'd0;
      th0       <= 8'd0;
      tl1       <= 8'd0;
      th1       <= 8'd0;
      last_pins <= 8'd0;
    end else begin
      if (!s1_valid || advance_en) begin
        s1_valid <= cmd_valid;
        if (cmd_valid) begin
          s1_op   <= op_t'(op);
          s1_addr <= reg_addr;
          s1_data <= write_data;
          s1_pins <= port_pins;
        end
      end
      if (advance_en) begin
        rsp_valid <= s1_valid;
        if (s1_valid) begin
          tcon      <= tcon_next;
          tmod      <= tmod_next;
          tl0       <= tl0_next;
          th0       <= th0_next;
          tl1       <= tl1_next;
          th1       <= th1_next;
          last_pins <= last_pins_next;
          read_data <= (s1_op == OP_READ) ? rd_value : 8'd0;
          addr_hit  <= hit;
          overflow0 <= tcon_next[TF0_BIT];
          overflow1 <= tcon_next[TF1_BIT];
        end
      end
    end
  end

endmodule
